// ===== src/spmd_pkg.sv =====
// ----------------------------------------------------------------------------
// spmd_pkg
// Shared widths, codes, reset values and bundle types for the signal pending
// mask dispatch block.
// ----------------------------------------------------------------------------
package spmd_pkg;

   localparam int SIG_MAX          = 31;
   localparam int NUM_SIGNALS_DEF  = 31;

   localparam int OP_W     = 2;
   localparam int SIG_W    = 5;
   localparam int CODE_W   = 8;
   localparam int EXTRA_W  = 32;
   localparam int HOW_W    = 2;
   localparam int SET_W    = 31;
   localparam int KIND_W   = 2;
   localparam int FLAG_W   = 2;
   localparam int OUTC_W   = 3;

   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 32;
   localparam int REG_IDX_W = 2;

   localparam logic [OP_W-1:0] OP_POST   = 2'd0;
   localparam logic [OP_W-1:0] OP_CHECK  = 2'd1;
   localparam logic [OP_W-1:0] OP_MASK   = 2'd2;
   localparam logic [OP_W-1:0] OP_ACTION = 2'd3;

   localparam logic [HOW_W-1:0] HOW_SET     = 2'd0;
   localparam logic [HOW_W-1:0] HOW_BLOCK   = 2'd1;
   localparam logic [HOW_W-1:0] HOW_UNBLOCK = 2'd2;

   localparam logic [KIND_W-1:0] KIND_DEFAULT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_IGNORE  = 2'd1;

   localparam int FLAG_RESET_BIT   = 0;
   localparam int FLAG_NODEFER_BIT = 1;

   localparam logic [OUTC_W-1:0] OUTC_DONE    = 3'd0;
   localparam logic [OUTC_W-1:0] OUTC_NONE    = 3'd1;
   localparam logic [OUTC_W-1:0] OUTC_IGNORED = 3'd2;
   localparam logic [OUTC_W-1:0] OUTC_STOP    = 3'd3;
   localparam logic [OUTC_W-1:0] OUTC_TERM    = 3'd4;
   localparam logic [OUTC_W-1:0] OUTC_DISCARD = 3'd5;
   localparam logic [OUTC_W-1:0] OUTC_HANDLER = 3'd6;

   localparam logic [REG_IDX_W-1:0] REG_TERM = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_STOP = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_CONT = 2'd2;

   localparam logic [SET_W-1:0] TERM_RESET = 31'h0000_55FF;
   localparam logic [SET_W-1:0] STOP_RESET = 31'h003C_0000;
   localparam logic [SIG_W-1:0] CONT_RESET = 5'd18;

   typedef struct packed {
      logic exec;
   } spmd_cmd_type;

   typedef struct packed {
      logic [SET_W-1:0] term_set;
      logic [SET_W-1:0] stop_set;
      logic [SIG_W-1:0] cont_signal;
   } spmd_cfg_type;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [SIG_W-1:0]   signal;
      logic [CODE_W-1:0]  info_code;
      logic [EXTRA_W-1:0] extra_info;
      logic [HOW_W-1:0]   how;
      logic [SET_W-1:0]   mask_value;
      logic [KIND_W-1:0]  handler_kind;
      logic               reset_on_delivery;
      logic               no_defer;
      logic [SET_W-1:0]   handler_mask;
   } spmd_req_type;

   typedef struct packed {
      logic [OUTC_W-1:0]  outcome;
      logic [SIG_W-1:0]   chosen_signal;
      logic [CODE_W-1:0]  chosen_code;
      logic [EXTRA_W-1:0] chosen_extra;
      logic               wake_task;
      logic [SET_W-1:0]   previous_mask;
      logic               error;
   } spmd_rsp_type;

endpackage

// ===== src/spmd_req_if.sv =====
// ----------------------------------------------------------------------------
// spmd_req_if
// Request channel of the signal unit: valid, ready and one item's fields.
// ----------------------------------------------------------------------------
interface spmd_req_if;
   import spmd_pkg::*;

   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    op;
   logic [SIG_W-1:0]   signal;
   logic [CODE_W-1:0]  info_code;
   logic [EXTRA_W-1:0] extra_info;
   logic [HOW_W-1:0]   how;
   logic [SET_W-1:0]   mask_value;
   logic [KIND_W-1:0]  handler_kind;
   logic               reset_on_delivery;
   logic               no_defer;
   logic [SET_W-1:0]   handler_mask;

   modport source (
      output valid, op, signal, info_code, extra_info, how, mask_value,
             handler_kind, reset_on_delivery, no_defer, handler_mask,
      input  ready
   );

   modport sink (
      input  valid, op, signal, info_code, extra_info, how, mask_value,
             handler_kind, reset_on_delivery, no_defer, handler_mask,
      output ready
   );
endinterface

// ===== src/spmd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// spmd_rsp_if
// Response channel of the signal unit: valid, ready and one result's fields.
// ----------------------------------------------------------------------------
interface spmd_rsp_if;
   import spmd_pkg::*;

   logic               valid;
   logic               ready;
   logic [OUTC_W-1:0]  outcome;
   logic [SIG_W-1:0]   chosen_signal;
   logic [CODE_W-1:0]  chosen_code;
   logic [EXTRA_W-1:0] chosen_extra;
   logic               wake_task;
   logic [SET_W-1:0]   previous_mask;
   logic               error;

   modport source (
      output valid, outcome, chosen_signal, chosen_code, chosen_extra,
             wake_task, previous_mask, error,
      input  ready
   );

   modport sink (
      input  valid, outcome, chosen_signal, chosen_code, chosen_extra,
             wake_task, previous_mask, error,
      output ready
   );
endinterface

// ===== src/spmd_csr.sv =====
// ----------------------------------------------------------------------------
// spmd_csr
// APB-style register file holding the default-action sets and the continue
// signal number.
// ----------------------------------------------------------------------------
module spmd_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [spmd_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [spmd_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [spmd_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready,
   output spmd_pkg::spmd_cfg_type        cfg
);
   import spmd_pkg::*;

   logic [SET_W-1:0]     term_ff;
   logic [SET_W-1:0]     stop_ff;
   logic [SIG_W-1:0]     cont_ff;
   logic                 wr_en;
   logic [REG_IDX_W-1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[CSR_AW-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         term_ff <= TERM_RESET;
         stop_ff <= STOP_RESET;
         cont_ff <= CONT_RESET;
      end else if (wr_en) begin
         case (reg_idx)
            REG_TERM: term_ff <= csr_pwdata[SET_W-1:0];
            REG_STOP: stop_ff <= csr_pwdata[SET_W-1:0];
            REG_CONT: cont_ff <= csr_pwdata[SIG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_TERM: csr_prdata = CSR_DW'(term_ff);
         REG_STOP: csr_prdata = CSR_DW'(stop_ff);
         REG_CONT: csr_prdata = CSR_DW'(cont_ff);
         default:  csr_prdata = '0;
      endcase
   end

   assign cfg.term_set    = term_ff;
   assign cfg.stop_set    = stop_ff;
   assign cfg.cont_signal = cont_ff;
endmodule

// ===== src/spmd_ctrl.sv =====
// ----------------------------------------------------------------------------
// spmd_ctrl
// Handshake controller: tracks whether the result register holds a transfer
// and commands the datapath to execute each accepted item.
// ----------------------------------------------------------------------------
module spmd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output spmd_pkg::spmd_cmd_type cmd
);
   import spmd_pkg::*;

   localparam logic [0:0] ST_EMPTY = 1'b0;
   localparam logic [0:0] ST_FULL  = 1'b1;

   logic [0:0] state_ff;
   logic [0:0] state_in;

   assign rsp_valid = (state_ff == ST_FULL);
   assign req_ready = (state_ff == ST_EMPTY) || rsp_ready;
   assign cmd.exec  = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_EMPTY: begin
            if (cmd.exec) state_in = ST_FULL;
         end
         ST_FULL: begin
            if (!cmd.exec && rsp_ready) state_in = ST_EMPTY;
         end
         default: state_in = ST_EMPTY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_EMPTY;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// ===== src/spmd_dp.sv =====
// ----------------------------------------------------------------------------
// spmd_dp
// Signal state datapath: pending and blocked sets, per-signal action and
// origin tables, priority pick and the registered result.
// ----------------------------------------------------------------------------
module spmd_dp #(
   parameter int NUM_SIGNALS = spmd_pkg::NUM_SIGNALS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  spmd_pkg::spmd_cmd_type cmd,
   input  spmd_pkg::spmd_cfg_type cfg,
   input  spmd_pkg::spmd_req_type req,
   output spmd_pkg::spmd_rsp_type rsp
);
   import spmd_pkg::*;

   localparam int NumSig = (NUM_SIGNALS < SIG_MAX) ? NUM_SIGNALS : SIG_MAX;
   localparam int IdxW   = $clog2(NumSig);

   typedef logic [NumSig-1:0] set_type;

   set_type            pending_ff, pending_in;
   set_type            blocked_ff, blocked_in;
   logic               stopped_ff, stopped_in;
   logic [KIND_W-1:0]  kind_ff  [NumSig];
   logic [KIND_W-1:0]  kind_in  [NumSig];
   logic [FLAG_W-1:0]  flag_ff  [NumSig];
   logic [FLAG_W-1:0]  flag_in  [NumSig];
   set_type            amask_ff [NumSig];
   set_type            amask_in [NumSig];
   logic [CODE_W-1:0]  code_ff  [NumSig];
   logic [EXTRA_W-1:0] extra_ff [NumSig];
   spmd_rsp_type       rsp_ff, rsp_in;

   logic               store_we;
   logic               sig_ok;
   logic               is_cont;
   logic [IdxW-1:0]    post_idx;
   logic [IdxW-1:0]    pick_idx;
   set_type            post_bit;
   set_type            ready_set;
   set_type            pick_bit;
   set_type            stop_set;
   set_type            term_set;
   set_type            mval;
   set_type            hmask;
   logic [KIND_W-1:0]  pick_kind;
   logic [FLAG_W-1:0]  pick_flag;

   assign sig_ok    = (req.signal != '0) && ({1'b0, req.signal} <= 6'(NumSig));
   assign is_cont   = (req.signal == cfg.cont_signal);
   assign post_idx  = IdxW'(req.signal - SIG_W'(1));
   assign post_bit  = set_type'(1) << post_idx;
   assign stop_set  = cfg.stop_set[NumSig-1:0];
   assign term_set  = cfg.term_set[NumSig-1:0];
   assign mval      = req.mask_value[NumSig-1:0];
   assign hmask     = req.handler_mask[NumSig-1:0];
   assign ready_set = pending_ff & ~blocked_ff;
   assign pick_bit  = ready_set & (~ready_set + set_type'(1));
   assign pick_kind = kind_ff[pick_idx];
   assign pick_flag = flag_ff[pick_idx];

   always_comb begin
      pick_idx = '0;
      for (int i = NumSig - 1; i >= 0; i--) begin
         if (ready_set[i]) pick_idx = IdxW'(i);
      end
   end

   always_comb begin
      pending_in = pending_ff;
      blocked_in = blocked_ff;
      stopped_in = stopped_ff;
      kind_in    = kind_ff;
      flag_in    = flag_ff;
      amask_in   = amask_ff;
      rsp_in     = rsp_ff;
      store_we   = 1'b0;
      if (cmd.exec) begin
         rsp_in               = '0;
         rsp_in.previous_mask = SET_W'(blocked_ff);
         case (req.op)
            OP_POST: begin
               if (!sig_ok) begin
                  rsp_in.error = 1'b1;
               end else begin
                  store_we = 1'b1;
                  if (is_cont) begin
                     pending_in = (pending_ff & ~stop_set) | post_bit;
                     stopped_in = 1'b0;
                     rsp_in.wake_task = stopped_ff;
                  end else begin
                     pending_in = pending_ff | post_bit;
                  end
               end
            end
            OP_CHECK: begin
               if (ready_set == '0) begin
                  rsp_in.outcome = OUTC_NONE;
               end else begin
                  pending_in           = pending_ff & ~pick_bit;
                  rsp_in.chosen_signal = SIG_W'(pick_idx) + SIG_W'(1);
                  rsp_in.chosen_code   = code_ff[pick_idx];
                  rsp_in.chosen_extra  = extra_ff[pick_idx];
                  case (pick_kind)
                     KIND_IGNORE: rsp_in.outcome = OUTC_IGNORED;
                     KIND_DEFAULT: begin
                        if ((pick_bit & stop_set) != '0) begin
                           stopped_in     = 1'b1;
                           rsp_in.outcome = OUTC_STOP;
                        end else if ((pick_bit & term_set) != '0) begin
                           rsp_in.outcome = OUTC_TERM;
                        end else begin
                           rsp_in.outcome = OUTC_DISCARD;
                        end
                     end
                     default: begin
                        rsp_in.outcome = OUTC_HANDLER;
                        blocked_in = blocked_ff | amask_ff[pick_idx]
                                   | (pick_flag[FLAG_NODEFER_BIT] ? '0 : pick_bit);
                        if (pick_flag[FLAG_RESET_BIT]) begin
                           kind_in[pick_idx]  = KIND_DEFAULT;
                           flag_in[pick_idx]  = '0;
                           amask_in[pick_idx] = '0;
                        end
                     end
                  endcase
               end
            end
            OP_MASK: begin
               case (req.how)
                  HOW_SET:     blocked_in = mval;
                  HOW_BLOCK:   blocked_in = blocked_ff | mval;
                  HOW_UNBLOCK: blocked_in = blocked_ff & ~mval;
                  default:     rsp_in.error = 1'b1;
               endcase
            end
            OP_ACTION: begin
               if (!sig_ok) begin
                  rsp_in.error = 1'b1;
               end else begin
                  kind_in[post_idx]  = req.handler_kind;
                  flag_in[post_idx]  = {req.no_defer, req.reset_on_delivery};
                  amask_in[post_idx] = hmask;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         blocked_ff <= '0;
         stopped_ff <= 1'b0;
         kind_ff    <= '{default: '0};
         flag_ff    <= '{default: '0};
         amask_ff   <= '{default: '0};
      end else begin
         pending_ff <= pending_in;
         blocked_ff <= blocked_in;
         stopped_ff <= stopped_in;
         kind_ff    <= kind_in;
         flag_ff    <= flag_in;
         amask_ff   <= amask_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (store_we) begin
         code_ff[post_idx]  <= req.info_code;
         extra_ff[post_idx] <= req.extra_info;
      end
   end

   assign rsp = rsp_ff;
endmodule

// ===== src/signal_pending_mask_dispatch.sv =====
// ----------------------------------------------------------------------------
// signal_pending_mask_dispatch
// Per-task signal unit: posts, dispatch checks, mask changes and action writes.
// ----------------------------------------------------------------------------
// Latency: a result is valid in the cycle after its request transfer.
// Throughput: one item per cycle while results are taken; the signal state is
// updated per transfer; the result register refills in the cycle it is taken.
// Reset clears the pending and blocked sets, the stopped flag and the action
// tables, and restores the register defaults; stored origin data is undefined
// until a signal is posted.
module signal_pending_mask_dispatch #(
   parameter int NUM_SIGNALS = spmd_pkg::NUM_SIGNALS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   spmd_req_if.sink                      req_ch,
   spmd_rsp_if.source                    rsp_ch,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [spmd_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [spmd_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [spmd_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import spmd_pkg::*;

   spmd_cmd_type cmd;
   spmd_cfg_type cfg;
   spmd_req_type req;
   spmd_rsp_type rsp;

   assign req.op                = req_ch.op;
   assign req.signal            = req_ch.signal;
   assign req.info_code         = req_ch.info_code;
   assign req.extra_info        = req_ch.extra_info;
   assign req.how               = req_ch.how;
   assign req.mask_value        = req_ch.mask_value;
   assign req.handler_kind      = req_ch.handler_kind;
   assign req.reset_on_delivery = req_ch.reset_on_delivery;
   assign req.no_defer          = req_ch.no_defer;
   assign req.handler_mask      = req_ch.handler_mask;

   assign rsp_ch.outcome       = rsp.outcome;
   assign rsp_ch.chosen_signal = rsp.chosen_signal;
   assign rsp_ch.chosen_code   = rsp.chosen_code;
   assign rsp_ch.chosen_extra  = rsp.chosen_extra;
   assign rsp_ch.wake_task     = rsp.wake_task;
   assign rsp_ch.previous_mask = rsp.previous_mask;
   assign rsp_ch.error         = rsp.error;

   spmd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   spmd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   spmd_dp #(
      .NUM_SIGNALS (NUM_SIGNALS)
   ) u_dp (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .cfg   (cfg),
      .req   (req),
      .rsp   (rsp)
   );
endmodule

// ===== src/spmd_checker.sv =====
// ----------------------------------------------------------------------------
// spmd_checker
// Port-level checks on the signal unit, bound to the top level.
// ----------------------------------------------------------------------------
module spmd_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [spmd_pkg::OUTC_W-1:0]  rsp_outcome,
   input logic [spmd_pkg::SIG_W-1:0]   rsp_chosen_signal,
   input logic                         rsp_wake_task,
   input logic                         rsp_error
);
   import spmd_pkg::*;

   // A result waiting to be taken stays on offer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before its transfer");

   // With the result register empty, a new request is always taken.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled while the result register is empty");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_outcome == OUTC_DONE && rsp_chosen_signal == '0
                                 && !rsp_wake_task)
      else $error("error result carries a dispatch or wake");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_outcome == OUTC_DONE || rsp_outcome == OUTC_NONE)
                     == (rsp_chosen_signal == '0)))
      else $error("chosen signal does not match the outcome");

   // A request accepted now always yields a result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted request produced no result");
endmodule

bind signal_pending_mask_dispatch spmd_checker u_spmd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_outcome       (rsp_ch.outcome),
   .rsp_chosen_signal (rsp_ch.chosen_signal),
   .rsp_wake_task     (rsp_ch.wake_task),
   .rsp_error         (rsp_ch.error)
);
